>>> design/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types and constants for the priority round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package prrs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PID_BITS    = 8;
   localparam int NUM_LEVELS  = 3;
   localparam logic [1:0] LOWEST_LEVEL = 2'd2;
   localparam logic [7:0] SLICE_RESET  = 8'd5;

   typedef enum logic [1:0] {
      FUNC_ENQUEUE  = 2'd0,
      FUNC_TICK     = 2'd1,
      FUNC_DISPATCH = 2'd2,
      FUNC_REMOVE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOTFOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [PID_BITS-1:0] pid;
      logic [1:0]          priority_req;
   } req_type;

   typedef struct packed {
      logic          running_valid;
      logic [7:0]    running_pid;
      logic          switched;
      logic [1:0]    status;
   } rsp_type;

   // Per-level command for a queue row: push at tail, pop head, remove pid.
   typedef struct packed {
      logic                push;
      logic                pop;
      logic                remove;
      logic [PID_BITS-1:0] pid;
   } prrs_qcmd_type;

   typedef struct packed {
      logic                found;
      logic                empty;
      logic                full;
      logic [PID_BITS-1:0] head;
   } prrs_qstat_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_DISP = 2'd2,
      ST_RESP = 2'd3
   } state_type;

endpackage
`default_nettype wire

>>> design/prrs_cell.sv
// ----------------------------------------------------------------------------
// prrs_cell
// One queue slot: holds a pid and a valid bit, shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none
module prrs_cell
   import prrs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift,
   input  wire logic                load,
   input  wire logic [PID_BITS-1:0] load_pid,
   input  wire logic                feed_valid,
   input  wire logic [PID_BITS-1:0] feed_pid,
   output logic                     valid,
   output logic [PID_BITS-1:0]      pid
);

   logic                valid_ff, valid_in;
   logic [PID_BITS-1:0] pid_ff, pid_in;

   always_comb begin
      valid_in = valid_ff;
      pid_in   = pid_ff;
      if (shift) begin
         valid_in = feed_valid;
         pid_in   = feed_pid;
      end else if (load) begin
         valid_in = 1'b1;
         pid_in   = load_pid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      pid_ff <= pid_in;
   end

   assign valid = valid_ff;
   assign pid   = pid_ff;

endmodule
`default_nettype wire

>>> design/prrs_queue.sv
// ----------------------------------------------------------------------------
// prrs_queue
// One priority level: a row of cells, valid entries packed at the head.
// ----------------------------------------------------------------------------
`default_nettype none
module prrs_queue
   import prrs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire prrs_qcmd_type  cmd,
   output prrs_qstat_type      stat
);

   logic [QUEUE_DEPTH-1:0]               vld;
   logic [QUEUE_DEPTH-1:0][PID_BITS-1:0] pids;
   logic [QUEUE_DEPTH-1:0]               match, hit_at_or_before, shift, load;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match[i] = vld[i] && (pids[i] == cmd.pid);
      end
      hit_at_or_before[0] = match[0];
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         hit_at_or_before[i] = hit_at_or_before[i-1] | match[i];
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         shift[i] = cmd.pop || (cmd.remove && hit_at_or_before[i]);
         if (i == 0) load[i] = cmd.push && !vld[0];
         else        load[i] = cmd.push && vld[i-1] && !vld[i];
      end
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                nv;
      logic [PID_BITS-1:0] np;
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign nv = 1'b0;
         assign np = '0;
      end else begin : g_mid
         assign nv = vld[g+1];
         assign np = pids[g+1];
      end
      prrs_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift[g]), .load(load[g]),
         .load_pid(cmd.pid), .feed_valid(nv), .feed_pid(np),
         .valid(vld[g]), .pid(pids[g])
      );
   end

   assign stat.found = hit_at_or_before[QUEUE_DEPTH-1];
   assign stat.empty = !vld[0];
   assign stat.full  = vld[QUEUE_DEPTH-1];
   assign stat.head  = pids[0];

   // Entries stay packed toward the head.
   for (genvar g = 1; g < QUEUE_DEPTH; g++) begin : g_chk
      assert property (@(posedge clock) disable iff (reset) vld[g] |-> vld[g-1])
         else $error("queue hole");
   end

endmodule
`default_nettype wire

>>> design/priority_round_robin_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_unit
// Three-level ready queues with time-slice round robin.
// ----------------------------------------------------------------------------
// Usage: each req_ transfer carries one command (enqueue, tick, dispatch,
// remove); exactly one rsp_ transfer follows with the running slot and a
// status code. The csr_ port writes the slice length at any idle time.
// Each level is a row of 16 cells; a remove compacts a row by shifting every
// cell from the match onward toward the head.
// Flow: a req_ transfer passes through the execute, dispatch and respond
// states before rsp_valid; req_ready returns only back in idle, so one
// item is in flight at a time.
// Reset: all queues empty, no process running, slice length 5.
// Stall: the response holds in its register while rsp_ready is low and
// req_ready stays low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module priority_round_robin_scheduler_unit
   import prrs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_write,
   input  wire logic [7:0] csr_data
);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [7:0] slice_length_ff;
   logic       run_valid_ff, run_valid_in;
   logic [PID_BITS-1:0] run_pid_ff, run_pid_in;
   logic [1:0] run_level_ff, run_level_in;
   logic [7:0] slice_left_ff, slice_left_in;
   logic       old_valid_ff;
   logic [PID_BITS-1:0] old_pid_ff;
   status_type status_ff, status_in;
   logic       disp_ff, disp_in;
   rsp_type    rsp_ff;

   prrs_qcmd_type  qcmd [NUM_LEVELS];
   prrs_qstat_type qst  [NUM_LEVELS];

   for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_lvl
      prrs_queue u_queue (.clock(clock), .reset(reset), .cmd(qcmd[l]), .stat(qst[l]));
   end

   logic [1:0] prio;
   logic       any_found;
   logic [7:0] slice_load;
   assign prio = (req_ff.priority_req > LOWEST_LEVEL) ? LOWEST_LEVEL : req_ff.priority_req;
   assign any_found = qst[0].found | qst[1].found | qst[2].found;
   assign slice_load = (slice_length_ff == 8'd0) ? 8'd1 : slice_length_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_DISP;
         ST_DISP: state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      run_valid_in = run_valid_ff;
      run_pid_in   = run_pid_ff;
      run_level_in = run_level_ff;
      slice_left_in = slice_left_ff;
      status_in    = status_ff;
      disp_in      = 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         qcmd[l] = '0;
         qcmd[l].pid = req_ff.pid;
      end
      case (state_ff)
         ST_EXEC: begin
            status_in = STATUS_OK;
            case (func_type'(req_ff.func))
               FUNC_ENQUEUE: begin
                  if (qst[prio].full) status_in = STATUS_FULL;
                  else qcmd[prio].push = 1'b1;
               end
               FUNC_TICK: begin
                  if (run_valid_ff) begin
                     if (slice_left_ff <= 8'd1) begin
                        if (qst[run_level_ff].full) begin
                           slice_left_in = slice_load;
                           status_in = STATUS_FULL;
                        end else begin
                           qcmd[run_level_ff].push = 1'b1;
                           qcmd[run_level_ff].pid  = run_pid_ff;
                           run_valid_in = 1'b0;
                           run_pid_in = '0;
                           run_level_in = '0;
                           slice_left_in = '0;
                           disp_in = 1'b1;
                        end
                     end else begin
                        slice_left_in = slice_left_ff - 8'd1;
                     end
                  end
               end
               FUNC_DISPATCH: disp_in = !run_valid_ff;
               FUNC_REMOVE: begin
                  for (int l = 0; l < NUM_LEVELS; l++) qcmd[l].remove = 1'b1;
                  if (run_valid_ff && run_pid_ff == req_ff.pid) begin
                     run_valid_in = 1'b0;
                     run_pid_in = '0;
                     run_level_in = '0;
                     slice_left_in = '0;
                  end else if (!any_found) begin
                     status_in = STATUS_NOTFOUND;
                  end
               end
               default: ;
            endcase
         end
         ST_DISP: begin
            if (disp_ff) begin
               if (!qst[0].empty) begin
                  qcmd[0].pop = 1'b1; run_pid_in = qst[0].head; run_level_in = 2'd0;
               end else if (!qst[1].empty) begin
                  qcmd[1].pop = 1'b1; run_pid_in = qst[1].head; run_level_in = 2'd1;
               end else if (!qst[2].empty) begin
                  qcmd[2].pop = 1'b1; run_pid_in = qst[2].head; run_level_in = 2'd2;
               end
               if (!(qst[0].empty && qst[1].empty && qst[2].empty)) begin
                  run_valid_in = 1'b1;
                  slice_left_in = slice_load;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slice_length_ff <= SLICE_RESET;
         run_valid_ff <= 1'b0;
         run_pid_ff <= '0;
         run_level_ff <= '0;
         slice_left_ff <= '0;
         disp_ff <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         if (csr_write) slice_length_ff <= csr_data;
         run_valid_ff <= run_valid_in;
         run_pid_ff <= run_pid_in;
         run_level_ff <= run_level_in;
         slice_left_ff <= slice_left_in;
         disp_ff <= disp_in;
         status_ff <= status_in;
      end
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
         old_valid_ff <= run_valid_ff;
         old_pid_ff <= run_pid_ff;
      end
      if (state_ff == ST_DISP) begin
         rsp_ff.running_valid <= run_valid_in;
         rsp_ff.running_pid   <= run_valid_in ? 8'(run_pid_in) : 8'd0;
         rsp_ff.switched <= (old_valid_ff != run_valid_in) ||
                            (run_valid_in && old_pid_ff != run_pid_in);
         rsp_ff.status <= status_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##3 rsp_valid) else $error("no response");
   assert property (@(posedge clock) disable iff (reset)
      !run_valid_ff |-> (run_pid_ff == '0)) else $error("idle pid not zero");
   assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> (slice_left_ff != 8'd0)) else $error("running without slice");
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("overlap");

endmodule
`default_nettype wire
